// ===== hw/rtl/mcdcn_pkg.sv =====
`timescale 1ns / 1ps

package mcdcn_pkg;

   // sizing
   localparam int NUM_CHANNELS = 14;
   localparam int FRAC_BITS    = 16;
   localparam int COEF_FRAC    = 16;
   localparam int CHAN_W       = 4;
   localparam int SAMPLE_W     = 24;
   localparam int OUT_W        = 16;
   localparam int ALPHA_W      = 16;
   localparam int COEF_W       = 18;
   localparam int STATE_W      = 48;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 18;
   localparam int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // product slicing: state word split into a signed high part and a 16-bit low part
   localparam int HI_W   = STATE_W - COEF_FRAC;
   localparam int LO_W   = COEF_FRAC + 1 + COEF_W;
   localparam int LOSH_W = LO_W - COEF_FRAC;
   localparam int MUL_W  = HI_W + COEF_W;
   localparam int DIFF_W = SAMPLE_W + 1;
   localparam int PAIR_W = MUL_W + 1;
   localparam int TSUM_W = MUL_W + 2;
   localparam int SUM_W  = MUL_W + 3;
   localparam int OUT_SHIFT = FRAC_BITS + 8;

   // queue and pipeline
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int PIPE_DEPTH  = 6;

   typedef logic signed [STATE_W-1:0] state_type;
   typedef logic signed [COEF_W-1:0]  coef_type;

   localparam state_type STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
   localparam state_type STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};
   localparam state_type Q_MAX     = state_type'(32767);
   localparam state_type Q_MIN     = state_type'(-32768);

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DC_ALPHA = 3'd0,
      REG_NOTCH_B0 = 3'd1,
      REG_NOTCH_B1 = 3'd2,
      REG_NOTCH_B2 = 3'd3,
      REG_NOTCH_A1 = 3'd4,
      REG_NOTCH_A2 = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic [ALPHA_W-1:0] dc_alpha;
      coef_type           b0;
      coef_type           b1;
      coef_type           b2;
      coef_type           a1;
      coef_type           a2;
   } coef_set_type;

   localparam coef_set_type COEF_RESET = '{
      dc_alpha: 16'd65208,
      b0:       18'sd63716,
      b1:       -18'sd121095,
      b2:       18'sd63716,
      a1:       18'sd121095,
      a2:       -18'sd61897
   };

   // queued item, classified on entry
   typedef struct packed {
      logic [CHAN_W-1:0]          channel;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       in_range;
   } item_type;

   // high partial product: floor(v / 2^16) * c
   function automatic logic signed [MUL_W-1:0] mul_hi(state_type v, coef_type c);
      logic signed [HI_W-1:0] h;
      h = v[STATE_W-1:COEF_FRAC];
      return h * c;
   endfunction

   // low partial product: floor((v mod 2^16) * c / 2^16)
   function automatic logic signed [LOSH_W-1:0] mul_lo(state_type v, coef_type c);
      logic signed [COEF_FRAC:0] l;
      logic signed [LO_W-1:0]    p;
      l = {1'b0, v[COEF_FRAC-1:0]};
      p = l * c;
      return p[LO_W-1:COEF_FRAC];
   endfunction

   // join the partial products into floor(v * c / 2^16)
   function automatic logic signed [MUL_W-1:0] mul_join(logic signed [MUL_W-1:0] hi,
                                                        logic signed [LOSH_W-1:0] lo);
      return hi + MUL_W'(lo);
   endfunction

   // clamp to the 48-bit state range
   function automatic state_type sat_state(logic signed [SUM_W-1:0] v);
      if (v > SUM_W'(STATE_MAX)) begin
         return STATE_MAX;
      end
      if (v < SUM_W'(STATE_MIN)) begin
         return STATE_MIN;
      end
      return v[STATE_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/mcdcn_if.sv =====
`timescale 1ns / 1ps

// sample request channel
interface mcdcn_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [mcdcn_pkg::CHAN_W-1:0]             channel;
   logic signed [mcdcn_pkg::SAMPLE_W-1:0]    sample;

   modport source (output valid, channel, sample, input ready);
   modport sink   (input valid, channel, sample, output ready);
endinterface

// filtered result channel
interface mcdcn_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic [mcdcn_pkg::CHAN_W-1:0]             out_channel;
   logic signed [mcdcn_pkg::OUT_W-1:0]       filtered;
   logic                                     clipped;

   modport source (output valid, out_channel, filtered, clipped, input ready);
   modport sink   (input valid, out_channel, filtered, clipped, output ready);
endinterface

// register write channel
interface mcdcn_csr_if;
   logic                                     valid;
   logic                                     ready;
   logic [mcdcn_pkg::CSR_IDX_W-1:0]          index;
   logic [mcdcn_pkg::CSR_DATA_W-1:0]         data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/mcdcn_csr.sv =====
`timescale 1ns / 1ps

module mcdcn_csr (
   input  logic                    clock,
   input  logic                    reset,
   mcdcn_csr_if.sink               csr_bus,
   output mcdcn_pkg::coef_set_type coef
);

   mcdcn_pkg::coef_set_type coef_ff;
   mcdcn_pkg::coef_set_type coef_in;

   // writes always complete in one transfer
   assign csr_bus.ready = 1'b1;
   assign coef          = coef_ff;

   // register decode, unused indexes dropped
   always_comb begin
      coef_in = coef_ff;
      if (csr_bus.valid) begin
         unique case (mcdcn_pkg::csr_reg_type'(csr_bus.index))
            mcdcn_pkg::REG_DC_ALPHA: coef_in.dc_alpha = csr_bus.data[mcdcn_pkg::ALPHA_W-1:0];
            mcdcn_pkg::REG_NOTCH_B0: coef_in.b0 = csr_bus.data;
            mcdcn_pkg::REG_NOTCH_B1: coef_in.b1 = csr_bus.data;
            mcdcn_pkg::REG_NOTCH_B2: coef_in.b2 = csr_bus.data;
            mcdcn_pkg::REG_NOTCH_A1: coef_in.a1 = csr_bus.data;
            mcdcn_pkg::REG_NOTCH_A2: coef_in.a2 = csr_bus.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= mcdcn_pkg::COEF_RESET;
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule

// ===== hw/rtl/mcdcn_front.sv =====
`timescale 1ns / 1ps

module mcdcn_front (
   input  logic                clock,
   input  logic                reset,
   mcdcn_req_if.sink           req_bus,
   output logic                q_valid,
   output mcdcn_pkg::item_type q_item,
   input  logic                q_ready
);

   mcdcn_pkg::item_type                queue_ff [mcdcn_pkg::QUEUE_DEPTH];
   logic [mcdcn_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [mcdcn_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [mcdcn_pkg::QPTR_W:0]         count_ff, count_in;
   mcdcn_pkg::item_type                new_item;
   logic                               push;
   logic                               pop;

   // classify the incoming sample
   always_comb begin
      new_item.channel  = req_bus.channel;
      new_item.sample   = req_bus.sample;
      new_item.in_range = 32'(req_bus.channel) < mcdcn_pkg::NUM_CHANNELS;
   end

   assign req_bus.ready = count_ff != (mcdcn_pkg::QPTR_W + 1)'(mcdcn_pkg::QUEUE_DEPTH);
   assign q_valid       = count_ff != '0;
   assign q_item        = queue_ff[rd_ptr_ff];
   assign push          = req_bus.valid && req_bus.ready;
   assign pop           = q_valid && q_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == mcdcn_pkg::QPTR_W'(mcdcn_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == mcdcn_pkg::QPTR_W'(mcdcn_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= mcdcn_pkg::QUEUE_DEPTH)
      else $error("queue fill count beyond depth");

endmodule

// ===== hw/rtl/mcdcn_back.sv =====
`timescale 1ns / 1ps

module mcdcn_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  mcdcn_pkg::item_type     q_item,
   output logic                    q_ready,
   input  mcdcn_pkg::coef_set_type coef,
   mcdcn_rsp_if.source             rsp_bus
);

   // item context carried down the pipe
   typedef struct packed {
      logic [mcdcn_pkg::CHAN_W-1:0]          channel;
      logic                                  in_range;
      logic [mcdcn_pkg::IDX_W-1:0]           idx;
      logic signed [mcdcn_pkg::SAMPLE_W-1:0] x;
      mcdcn_pkg::state_type                  d1;
      mcdcn_pkg::state_type                  y1;
   } ctx_type;

   typedef struct packed {
      ctx_type                               ctx;
      logic signed [mcdcn_pkg::SAMPLE_W-1:0] xp;
      mcdcn_pkg::state_type                  d2;
      mcdcn_pkg::state_type                  y2;
   } s1_type;

   typedef struct packed {
      ctx_type                               ctx;
      logic signed [mcdcn_pkg::DIFF_W-1:0]   diff;
      logic signed [mcdcn_pkg::MUL_W-1:0]    al_hi;
      logic signed [mcdcn_pkg::LOSH_W-1:0]   al_lo;
      logic signed [mcdcn_pkg::MUL_W-1:0]    b1_hi;
      logic signed [mcdcn_pkg::LOSH_W-1:0]   b1_lo;
      logic signed [mcdcn_pkg::MUL_W-1:0]    b2_hi;
      logic signed [mcdcn_pkg::LOSH_W-1:0]   b2_lo;
      logic signed [mcdcn_pkg::MUL_W-1:0]    a1_hi;
      logic signed [mcdcn_pkg::LOSH_W-1:0]   a1_lo;
      logic signed [mcdcn_pkg::MUL_W-1:0]    a2_hi;
      logic signed [mcdcn_pkg::LOSH_W-1:0]   a2_lo;
   } s2_type;

   typedef struct packed {
      ctx_type                               ctx;
      logic signed [mcdcn_pkg::SUM_W-1:0]    d_raw;
      logic signed [mcdcn_pkg::MUL_W-1:0]    m_b1;
      logic signed [mcdcn_pkg::MUL_W-1:0]    m_b2;
      logic signed [mcdcn_pkg::MUL_W-1:0]    m_a1;
      logic signed [mcdcn_pkg::MUL_W-1:0]    m_a2;
   } s3_type;

   typedef struct packed {
      ctx_type                               ctx;
      mcdcn_pkg::state_type                  d;
      logic signed [mcdcn_pkg::PAIR_W-1:0]   t_b;
      logic signed [mcdcn_pkg::PAIR_W-1:0]   t_a;
   } s4_type;

   typedef struct packed {
      ctx_type                               ctx;
      mcdcn_pkg::state_type                  d;
      logic signed [mcdcn_pkg::MUL_W-1:0]    b0_hi;
      logic signed [mcdcn_pkg::LOSH_W-1:0]   b0_lo;
      logic signed [mcdcn_pkg::TSUM_W-1:0]   t;
   } s5_type;

   typedef struct packed {
      ctx_type                               ctx;
      mcdcn_pkg::state_type                  d;
      logic signed [mcdcn_pkg::SUM_W-1:0]    y_raw;
   } s6_type;

   // per-channel history
   logic signed [mcdcn_pkg::SAMPLE_W-1:0] xp_ff [mcdcn_pkg::NUM_CHANNELS];
   mcdcn_pkg::state_type                  d1_ff [mcdcn_pkg::NUM_CHANNELS];
   mcdcn_pkg::state_type                  d2_ff [mcdcn_pkg::NUM_CHANNELS];
   mcdcn_pkg::state_type                  y1_ff [mcdcn_pkg::NUM_CHANNELS];
   mcdcn_pkg::state_type                  y2_ff [mcdcn_pkg::NUM_CHANNELS];
   logic [mcdcn_pkg::NUM_CHANNELS-1:0]    hist_valid_ff, hist_valid_in;
   logic [mcdcn_pkg::NUM_CHANNELS-1:0]    busy_ff, busy_in;

   // pipe stages
   logic [mcdcn_pkg::PIPE_DEPTH-1:0]      valid_ff, valid_in;
   logic [mcdcn_pkg::PIPE_DEPTH-1:0]      inflight;
   s1_type                                s1_ff, s1_in;
   s2_type                                s2_ff, s2_in;
   s3_type                                s3_ff, s3_in;
   s4_type                                s4_ff, s4_in;
   s5_type                                s5_ff, s5_in;
   s6_type                                s6_ff, s6_in;

   // result register
   logic                                  out_valid_ff, out_valid_in;
   logic [mcdcn_pkg::CHAN_W-1:0]          out_channel_ff, out_channel_in;
   logic signed [mcdcn_pkg::OUT_W-1:0]    filtered_ff, filtered_in;
   logic                                  clipped_ff, clipped_in;

   logic                                  adv;
   logic                                  issue;
   logic                                  wb;
   logic [mcdcn_pkg::IDX_W-1:0]           rd_idx;
   logic                                  rd_hit;
   logic signed [mcdcn_pkg::COEF_W-1:0]   alpha_c;
   mcdcn_pkg::state_type                  y;
   mcdcn_pkg::state_type                  q;

   // whole pipe moves when the result register can take a transfer
   assign adv     = !out_valid_ff || rsp_bus.ready;
   assign rd_idx  = mcdcn_pkg::IDX_W'(q_item.channel);
   assign q_ready = adv && (!q_item.in_range || !busy_ff[rd_idx]);
   assign issue   = q_valid && q_ready;
   assign wb      = adv && valid_ff[mcdcn_pkg::PIPE_DEPTH-1] && s6_ff.ctx.in_range;
   assign alpha_c = {{(mcdcn_pkg::COEF_W - mcdcn_pkg::ALPHA_W){1'b0}}, coef.dc_alpha};

   // stage 1: history read, unwritten channels read as zero
   always_comb begin
      rd_hit           = q_item.in_range && hist_valid_ff[rd_idx];
      s1_in.ctx.channel  = q_item.channel;
      s1_in.ctx.in_range = q_item.in_range;
      s1_in.ctx.idx      = rd_idx;
      s1_in.ctx.x        = q_item.sample;
      s1_in.ctx.d1       = rd_hit ? d1_ff[rd_idx] : '0;
      s1_in.ctx.y1       = rd_hit ? y1_ff[rd_idx] : '0;
      s1_in.xp           = rd_hit ? xp_ff[rd_idx] : '0;
      s1_in.d2           = rd_hit ? d2_ff[rd_idx] : '0;
      s1_in.y2           = rd_hit ? y2_ff[rd_idx] : '0;
   end

   // stage 2: partial products on the old history
   always_comb begin
      s2_in.ctx   = s1_ff.ctx;
      s2_in.diff  = mcdcn_pkg::DIFF_W'(s1_ff.ctx.x) - mcdcn_pkg::DIFF_W'(s1_ff.xp);
      s2_in.al_hi = mcdcn_pkg::mul_hi(s1_ff.ctx.d1, alpha_c);
      s2_in.al_lo = mcdcn_pkg::mul_lo(s1_ff.ctx.d1, alpha_c);
      s2_in.b1_hi = mcdcn_pkg::mul_hi(s1_ff.ctx.d1, coef.b1);
      s2_in.b1_lo = mcdcn_pkg::mul_lo(s1_ff.ctx.d1, coef.b1);
      s2_in.b2_hi = mcdcn_pkg::mul_hi(s1_ff.d2, coef.b2);
      s2_in.b2_lo = mcdcn_pkg::mul_lo(s1_ff.d2, coef.b2);
      s2_in.a1_hi = mcdcn_pkg::mul_hi(s1_ff.ctx.y1, coef.a1);
      s2_in.a1_lo = mcdcn_pkg::mul_lo(s1_ff.ctx.y1, coef.a1);
      s2_in.a2_hi = mcdcn_pkg::mul_hi(s1_ff.y2, coef.a2);
      s2_in.a2_lo = mcdcn_pkg::mul_lo(s1_ff.y2, coef.a2);
   end

   // stage 3: join partials, raw dc blocker sum
   always_comb begin
      s3_in.ctx   = s2_ff.ctx;
      s3_in.d_raw = (mcdcn_pkg::SUM_W'(s2_ff.diff) <<< mcdcn_pkg::FRAC_BITS)
                  + mcdcn_pkg::SUM_W'(mcdcn_pkg::mul_join(s2_ff.al_hi, s2_ff.al_lo));
      s3_in.m_b1  = mcdcn_pkg::mul_join(s2_ff.b1_hi, s2_ff.b1_lo);
      s3_in.m_b2  = mcdcn_pkg::mul_join(s2_ff.b2_hi, s2_ff.b2_lo);
      s3_in.m_a1  = mcdcn_pkg::mul_join(s2_ff.a1_hi, s2_ff.a1_lo);
      s3_in.m_a2  = mcdcn_pkg::mul_join(s2_ff.a2_hi, s2_ff.a2_lo);
   end

   // stage 4: clamp dc output, pair the history terms
   always_comb begin
      s4_in.ctx = s3_ff.ctx;
      s4_in.d   = mcdcn_pkg::sat_state(s3_ff.d_raw);
      s4_in.t_b = mcdcn_pkg::PAIR_W'(s3_ff.m_b1) + mcdcn_pkg::PAIR_W'(s3_ff.m_b2);
      s4_in.t_a = mcdcn_pkg::PAIR_W'(s3_ff.m_a1) + mcdcn_pkg::PAIR_W'(s3_ff.m_a2);
   end

   // stage 5: b0 partials on the new dc output
   always_comb begin
      s5_in.ctx   = s4_ff.ctx;
      s5_in.d     = s4_ff.d;
      s5_in.b0_hi = mcdcn_pkg::mul_hi(s4_ff.d, coef.b0);
      s5_in.b0_lo = mcdcn_pkg::mul_lo(s4_ff.d, coef.b0);
      s5_in.t     = mcdcn_pkg::TSUM_W'(s4_ff.t_b) + mcdcn_pkg::TSUM_W'(s4_ff.t_a);
   end

   // stage 6: raw notch sum
   always_comb begin
      s6_in.ctx   = s5_ff.ctx;
      s6_in.d     = s5_ff.d;
      s6_in.y_raw = mcdcn_pkg::SUM_W'(mcdcn_pkg::mul_join(s5_ff.b0_hi, s5_ff.b0_lo))
                  + mcdcn_pkg::SUM_W'(s5_ff.t);
   end

   // write-back stage: clamp, scale to 16 bits, load the result register
   always_comb begin
      y              = mcdcn_pkg::sat_state(s6_ff.y_raw);
      q              = y >>> mcdcn_pkg::OUT_SHIFT;
      out_valid_in   = out_valid_ff;
      out_channel_in = out_channel_ff;
      filtered_in    = filtered_ff;
      clipped_in     = clipped_ff;
      if (adv) begin
         out_valid_in = valid_ff[mcdcn_pkg::PIPE_DEPTH-1];
         if (valid_ff[mcdcn_pkg::PIPE_DEPTH-1]) begin
            out_channel_in = s6_ff.ctx.channel;
            if (!s6_ff.ctx.in_range) begin
               filtered_in = '0;
               clipped_in  = 1'b0;
            end else if (q > mcdcn_pkg::Q_MAX) begin
               filtered_in = mcdcn_pkg::Q_MAX[mcdcn_pkg::OUT_W-1:0];
               clipped_in  = 1'b1;
            end else if (q < mcdcn_pkg::Q_MIN) begin
               filtered_in = mcdcn_pkg::Q_MIN[mcdcn_pkg::OUT_W-1:0];
               clipped_in  = 1'b1;
            end else begin
               filtered_in = q[mcdcn_pkg::OUT_W-1:0];
               clipped_in  = 1'b0;
            end
         end
      end
   end

   // stage valids, channel interlock and history valid bits
   always_comb begin
      valid_in      = valid_ff;
      busy_in       = busy_ff;
      hist_valid_in = hist_valid_ff;
      if (adv) begin
         valid_in = {valid_ff[mcdcn_pkg::PIPE_DEPTH-2:0], issue};
      end
      if (wb) begin
         busy_in[s6_ff.ctx.idx]       = 1'b0;
         hist_valid_in[s6_ff.ctx.idx] = 1'b1;
      end
      if (issue && q_item.in_range) begin
         busy_in[rd_idx] = 1'b1;
      end
      for (int k = 0; k < mcdcn_pkg::PIPE_DEPTH; k++) begin
         inflight[k] = 1'b0;
      end
      inflight[0] = valid_ff[0] && s1_ff.ctx.in_range;
      inflight[1] = valid_ff[1] && s2_ff.ctx.in_range;
      inflight[2] = valid_ff[2] && s3_ff.ctx.in_range;
      inflight[3] = valid_ff[3] && s4_ff.ctx.in_range;
      inflight[4] = valid_ff[4] && s5_ff.ctx.in_range;
      inflight[5] = valid_ff[5] && s6_ff.ctx.in_range;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         busy_ff       <= '0;
         hist_valid_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         busy_ff       <= busy_in;
         hist_valid_ff <= hist_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
      end
      out_channel_ff <= out_channel_in;
      filtered_ff    <= filtered_in;
      clipped_ff     <= clipped_in;
   end

   // history write-back, shifting the delay line
   always_ff @(posedge clock) begin
      if (wb) begin
         xp_ff[s6_ff.ctx.idx] <= s6_ff.ctx.x;
         d1_ff[s6_ff.ctx.idx] <= s6_ff.d;
         d2_ff[s6_ff.ctx.idx] <= s6_ff.ctx.d1;
         y1_ff[s6_ff.ctx.idx] <= y;
         y2_ff[s6_ff.ctx.idx] <= s6_ff.ctx.y1;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.out_channel = out_channel_ff;
   assign rsp_bus.filtered    = filtered_ff;
   assign rsp_bus.clipped     = clipped_ff;

   a_busy_matches_pipe: assert property (@(posedge clock) disable iff (reset)
      $countones(busy_ff) == $countones(inflight))
      else $error("channel busy bits disagree with items in flight");

   a_wb_channel_busy: assert property (@(posedge clock) disable iff (reset)
      valid_ff[mcdcn_pkg::PIPE_DEPTH-1] && s6_ff.ctx.in_range |-> busy_ff[s6_ff.ctx.idx])
      else $error("write-back to a channel not marked busy");

   a_clip_at_rail: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && clipped_ff |->
         filtered_ff == mcdcn_pkg::Q_MAX[mcdcn_pkg::OUT_W-1:0] ||
         filtered_ff == mcdcn_pkg::Q_MIN[mcdcn_pkg::OUT_W-1:0])
      else $error("clip flag set without a saturated result");

endmodule

// ===== hw/rtl/multichannel_dc_block_notch_filter.sv =====
`timescale 1ns / 1ps

// channel   | dir | transfer                                | payload
// req_bus   | in  | req_bus.valid && req_bus.ready          | channel, sample
// rsp_bus   | out | rsp_bus.valid && rsp_bus.ready          | out_channel, filtered, clipped
// csr_bus   | in  | csr_bus.valid && csr_bus.ready          | index, data
//
// a request passes through a 4-entry queue, a 6-stage multiply pipeline and the result
// register; one item enters the pipe per cycle while the pipe is not stalled
// an item waits while an earlier one on the same channel is still in the pipe, so
// items on one channel never overlap in the pipe (history write-back loop)
// reset is synchronous: coefficients go to defaults, history reads as zero, no sweep
// a stalled result freezes the pipe; requests keep filling the queue until it is full

module multichannel_dc_block_notch_filter (
   input logic          clock,
   input logic          reset,
   mcdcn_req_if.sink    req_bus,
   mcdcn_rsp_if.source  rsp_bus,
   mcdcn_csr_if.sink    csr_bus
);

   logic                    q_valid;
   logic                    q_ready;
   mcdcn_pkg::item_type     q_item;
   mcdcn_pkg::coef_set_type coef;

   // coefficient registers
   mcdcn_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .coef    (coef)
   );

   // request queue
   mcdcn_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_ready (q_ready)
   );

   // filter pipeline and channel history
   mcdcn_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_ready (q_ready),
      .coef    (coef),
      .rsp_bus (rsp_bus)
   );

endmodule
